FILE: sv/isbs_pkg.sv
// Package for the serial bus byte sender: phase encoding, operation and
// register index codes, configuration reset values, shared struct types.
// No dependencies.
package isbs_pkg;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SETUP = 2'd1,
      PH_VALID = 2'd2,
      PH_ACK   = 2'd3
   } phase_type;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_BITS     = 16;
   localparam int BYTE_BITS    = 8;
   localparam int BITCNT_BITS  = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_BIT_SETUP  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_BIT_VALID  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_POLL_TICKS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_POLL_COUNT = 2'd3;

   localparam logic [CSR_BITS-1:0] RST_BIT_SETUP  = 16'd70;
   localparam logic [CSR_BITS-1:0] RST_BIT_VALID  = 16'd20;
   localparam logic [CSR_BITS-1:0] RST_POLL_TICKS = 16'd10;
   localparam logic [CSR_BITS-1:0] RST_POLL_COUNT = 16'd100;

   localparam logic [BITCNT_BITS-1:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic [CSR_BITS-1:0] bit_setup_ticks;
      logic [CSR_BITS-1:0] bit_valid_ticks;
      logic [CSR_BITS-1:0] ack_poll_ticks;
      logic [CSR_BITS-1:0] ack_poll_count;
   } cfg_type;

   typedef struct packed {
      logic clock_drive;
      logic data_drive;
      logic busy_res;
      logic done_res;
      logic acknowledged;
   } result_type;

endpackage

FILE: sv/isbs_csr.sv
// Configuration register file for the serial bus byte sender.
// Depends on isbs_pkg.
module isbs_csr
   import isbs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_setup_ticks <= RST_BIT_SETUP;
         cfg_ff.bit_valid_ticks <= RST_BIT_VALID;
         cfg_ff.ack_poll_ticks  <= RST_POLL_TICKS;
         cfg_ff.ack_poll_count  <= RST_POLL_COUNT;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BIT_SETUP:  cfg_ff.bit_setup_ticks <= csr_wdata;
            REG_BIT_VALID:  cfg_ff.bit_valid_ticks <= csr_wdata;
            REG_POLL_TICKS: cfg_ff.ack_poll_ticks  <= csr_wdata;
            REG_POLL_COUNT: cfg_ff.ack_poll_count  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/isbs_core.sv
// Transfer state machine with bit, delay and poll counters; produces one
// result per accepted beat. Depends on isbs_pkg.
module isbs_core
   import isbs_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 operation,
   input  logic [BYTE_BITS-1:0] byte_value,
   input  logic                 data_line_in,
   input  cfg_type              cfg,
   output result_type           result
);

   phase_type                phase_ff, phase_in;
   logic [BYTE_BITS-1:0]     shift_byte_ff, shift_byte_in;
   logic [BITCNT_BITS-1:0]   bit_count_ff, bit_count_in;
   logic [TIMER_BITS-1:0]    delay_count_ff, delay_count_in;
   logic [CSR_BITS-1:0]      poll_count_ff, poll_count_in;
   logic                     data_driven_ff, data_driven_in;

   logic is_tick, wait_done, last_bit, poll_spent, done, ack;

   assign is_tick    = (operation == OP_TICK);
   assign wait_done  = (delay_count_ff <= TIMER_BITS'(1));
   assign last_bit   = (bit_count_ff == LAST_BIT);
   assign poll_spent = (poll_count_ff >= cfg.ack_poll_count);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (!is_tick) phase_in = PH_SETUP;
         end
         PH_SETUP: begin
            if (is_tick && wait_done) phase_in = PH_VALID;
         end
         PH_VALID: begin
            if (is_tick && wait_done) phase_in = last_bit ? PH_ACK : PH_SETUP;
         end
         PH_ACK: begin
            if (is_tick && wait_done && (poll_spent || data_line_in)) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // counters, data line and result flags
   always_comb begin
      shift_byte_in  = shift_byte_ff;
      bit_count_in   = bit_count_ff;
      delay_count_in = delay_count_ff;
      poll_count_in  = poll_count_ff;
      data_driven_in = data_driven_ff;
      done           = 1'b0;
      ack            = 1'b0;
      if (!is_tick) begin
         if (phase_ff == PH_IDLE) begin
            shift_byte_in  = byte_value;
            bit_count_in   = '0;
            poll_count_in  = '0;
            data_driven_in = 1'b0;
            delay_count_in = TIMER_BITS'(cfg.bit_setup_ticks);
         end
      end else if (phase_ff != PH_IDLE) begin
         if (!wait_done) begin
            delay_count_in = delay_count_ff - TIMER_BITS'(1);
         end else begin
            case (phase_ff)
               PH_SETUP: begin
                  data_driven_in = ~shift_byte_ff[bit_count_ff];
                  delay_count_in = TIMER_BITS'(cfg.bit_valid_ticks);
               end
               PH_VALID: begin
                  data_driven_in = 1'b0;
                  if (last_bit) begin
                     bit_count_in   = '0;
                     poll_count_in  = '0;
                     delay_count_in = '0;
                  end else begin
                     bit_count_in   = bit_count_ff + BITCNT_BITS'(1);
                     delay_count_in = TIMER_BITS'(cfg.bit_setup_ticks);
                  end
               end
               PH_ACK: begin
                  if (poll_spent) begin
                     done = 1'b1;
                  end else if (data_line_in) begin
                     done = 1'b1;
                     ack  = 1'b1;
                  end else begin
                     poll_count_in  = poll_count_ff + CSR_BITS'(1);
                     delay_count_in = TIMER_BITS'(cfg.ack_poll_ticks);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         shift_byte_ff  <= '0;
         bit_count_ff   <= '0;
         delay_count_ff <= '0;
         poll_count_ff  <= '0;
         data_driven_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         shift_byte_ff  <= shift_byte_in;
         bit_count_ff   <= bit_count_in;
         delay_count_ff <= delay_count_in;
         poll_count_ff  <= poll_count_in;
         data_driven_ff <= data_driven_in;
      end
   end

   assign result.clock_drive  = (phase_in != PH_VALID);
   assign result.data_drive   = data_driven_in;
   assign result.busy_res     = (phase_in != PH_IDLE);
   assign result.done_res     = done;
   assign result.acknowledged = ack;

endmodule

FILE: sv/isbs_skid.sv
// Result register with one skid entry; keeps input ready registered.
// Depends on isbs_pkg.
module isbs_skid
   import isbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       push_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;
   logic       pop;

   assign pop = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= push_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= push_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

endmodule

FILE: sv/iec_serial_byte_sender.sv
// Talker side of a serial bus byte transfer, one beat per tick or start command.
// One beat is taken each clock cycle while req_ready is high; its result is registered
// in the result register or skid. A one-entry skid behind the result register keeps
// req_ready registered: when a result waits on rsp_, the skid takes one more beat and
// req_ready drops on the next cycle, rising again the cycle after the waiting result
// is taken. Depends on isbs_pkg, isbs_csr, isbs_core and isbs_skid.
module iec_serial_byte_sender
   import isbs_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   input  logic [BYTE_BITS-1:0]    req_byte_value,
   input  logic                    req_data_line_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_clock_drive,
   output logic                    rsp_data_drive,
   output logic                    rsp_busy_res,
   output logic                    rsp_done_res,
   output logic                    rsp_acknowledged
);

   cfg_type    cfg;
   result_type step_result, rsp_data;
   logic       step_en;

   assign csr_ready = 1'b1;
   assign step_en   = req_valid && req_ready;

   isbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   isbs_core #(.TIMER_BITS(TIMER_BITS)) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .operation    (req_operation),
      .byte_value   (req_byte_value),
      .data_line_in (req_data_line_in),
      .cfg          (cfg),
      .result       (step_result)
   );

   isbs_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (step_en),
      .push_data  (step_result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_clock_drive  = rsp_data.clock_drive;
   assign rsp_data_drive   = rsp_data.data_drive;
   assign rsp_busy_res     = rsp_data.busy_res;
   assign rsp_done_res     = rsp_data.done_res;
   assign rsp_acknowledged = rsp_data.acknowledged;

   a_ack_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_acknowledged |-> rsp_done_res)
      else $error("acknowledge without done");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done beat still busy");

   a_release_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_clock_drive |-> rsp_busy_res)
      else $error("clock released while idle");

   a_stall_drops_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty result register");

endmodule
